@@ rtl/mstt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_pkg
// shared types and codes for the multi-slot timer table
// ----------------------------------------------------------------------------
package mstt_pkg;

   localparam int HANDLE_W   = 32;
   localparam int DURATION_W = 32;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;

   typedef logic [OP_W-1:0]   op_code_type;
   typedef logic [KIND_W-1:0] kind_type;

   // request opcodes
   localparam op_code_type OP_SET    = 2'd0;
   localparam op_code_type OP_CANCEL = 2'd1;
   localparam op_code_type OP_TICK   = 2'd2;

   // result kinds
   localparam kind_type KIND_SET    = 2'd0;
   localparam kind_type KIND_CANCEL = 2'd1;
   localparam kind_type KIND_EXPIRY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET,
      ST_CANCEL,
      ST_TICK,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_INC,
      IDX_ZERO
   } idx_cmd_type;

   typedef enum logic [1:0] {
      ID_NONE,
      ID_NEXT,
      ID_PEND
   } id_sel_type;

   typedef struct packed {
      logic        req_load;
      idx_cmd_type idx;
      logic        alloc;
      logic        set_cancel;
      logic        free_cur;
      logic        dec;
      logic        pend_load;
      logic        pend_clr;
      logic        out_load;
      kind_type    out_kind;
      logic        out_ok;
      logic        out_last;
      id_sel_type  out_id_sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic idx_end;
      logic live;
      logic cancelled;
      logic id_match;
      logic rem_zero;
      logic out_free;
      logic pend_valid;
   } ctl_status_type;

endpackage

@@ rtl/mstt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mstt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_ctrl
// sequencer for set, cancel and tick scans over the slot table
// ----------------------------------------------------------------------------
module mstt_ctrl
   import mstt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  op_code_type    req_op,
   output logic           req_ready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      logic adv;
      adv        = 1'b0;
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.idx    = IDX_HOLD;
      cmd.out_id_sel = ID_NONE;
      cmd.out_kind   = KIND_SET;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_op)
                  OP_SET: begin
                     cmd.req_load = 1'b1;
                     state_in     = ST_SET;
                  end
                  OP_CANCEL: begin
                     cmd.req_load = 1'b1;
                     state_in     = ST_CANCEL;
                  end
                  OP_TICK: begin
                     state_in = ST_TICK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SET: begin
            if (!status.live || status.idx_end) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_SET;
                  cmd.out_last = 1'b1;
                  if (!status.live) begin
                     cmd.alloc      = 1'b1;
                     cmd.out_ok     = 1'b1;
                     cmd.out_id_sel = ID_NEXT;
                  end
                  cmd.idx  = IDX_ZERO;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.idx = IDX_INC;
            end
         end

         ST_CANCEL: begin
            if ((status.live && status.id_match) || status.idx_end) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_CANCEL;
                  cmd.out_last = 1'b1;
                  if (status.live && status.id_match && !status.cancelled) begin
                     cmd.set_cancel = 1'b1;
                     cmd.out_ok     = 1'b1;
                  end
                  cmd.idx  = IDX_ZERO;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.idx = IDX_INC;
            end
         end

         ST_TICK: begin
            if (!status.live) begin
               adv = 1'b1;
            end else if (status.cancelled) begin
               cmd.free_cur = 1'b1;
               adv          = 1'b1;
            end else if (status.rem_zero) begin
               if (!status.pend_valid) begin
                  cmd.pend_load = 1'b1;
                  cmd.free_cur  = 1'b1;
                  adv           = 1'b1;
               end else if (status.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = KIND_EXPIRY;
                  cmd.out_ok     = 1'b1;
                  cmd.out_id_sel = ID_PEND;
                  cmd.pend_load  = 1'b1;
                  cmd.free_cur   = 1'b1;
                  adv            = 1'b1;
               end
            end else begin
               cmd.dec = 1'b1;
               adv     = 1'b1;
            end
            if (adv) begin
               if (status.idx_end) begin
                  cmd.idx  = IDX_ZERO;
                  state_in = ST_FLUSH;
               end else begin
                  cmd.idx = IDX_INC;
               end
            end
         end

         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_EXPIRY;
               cmd.out_ok     = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.out_id_sel = ID_PEND;
               cmd.pend_clr   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/mstt_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_dpath
// slot storage, scan index, id counter, pending expiry and result register
// ----------------------------------------------------------------------------
module mstt_dpath
   import mstt_pkg::*;
#(
   parameter int NUM_SLOTS = 16,
   parameter int ID_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DURATION_W-1:0] req_duration_ms,
   input  logic [HANDLE_W-1:0]   req_cancel_id,
   input  ctl_cmd_type           cmd,
   output ctl_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kind_type              rsp_kind,
   output logic                  rsp_ok,
   output logic [HANDLE_W-1:0]   rsp_handle,
   output logic                  rsp_last
);

   localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
   localparam int RAM_W = ID_BITS + DURATION_W;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [NUM_SLOTS-1:0]  live_ff, live_in;
   logic [NUM_SLOTS-1:0]  cancel_ff, cancel_in;
   logic [ID_BITS-1:0]    next_id_ff, next_id_in, next_id_inc;
   logic [DURATION_W-1:0] dur_ff;
   logic [HANDLE_W-1:0]   cid_ff;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]    pend_id_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff;
   logic                  rsp_ok_ff;
   logic                  rsp_last_ff;
   logic [HANDLE_W-1:0]   rsp_id_ff, rsp_id_in;

   logic                  idx_end;
   logic                  ram_we;
   logic [RAM_W-1:0]      ram_wdata;
   logic [RAM_W-1:0]      ram_rdata;
   logic [ID_BITS-1:0]    rd_id;
   logic [DURATION_W-1:0] rd_rem;

   assign idx_end = (idx_ff == IDX_W'(NUM_SLOTS - 1));
   assign rd_id   = ram_rdata[RAM_W-1 -: ID_BITS];
   assign rd_rem  = ram_rdata[DURATION_W-1:0];

   // read address follows the next index so data lines up with the slot
   always_comb begin
      case (cmd.idx)
         IDX_INC:  idx_in = idx_end ? '0 : IDX_W'(idx_ff + 1'b1);
         IDX_ZERO: idx_in = '0;
         default:  idx_in = idx_ff;
      endcase
   end

   assign next_id_inc = ID_BITS'(next_id_ff + 1'b1);

   always_comb begin
      live_in       = live_ff;
      cancel_in     = cancel_ff;
      next_id_in    = next_id_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.alloc) begin
         live_in[idx_ff]   = 1'b1;
         cancel_in[idx_ff] = 1'b0;
         next_id_in        = (next_id_inc == '0) ? ID_BITS'(1) : next_id_inc;
      end
      if (cmd.set_cancel) begin
         cancel_in[idx_ff] = 1'b1;
      end
      if (cmd.free_cur) begin
         live_in[idx_ff]   = 1'b0;
         cancel_in[idx_ff] = 1'b0;
      end
      if (cmd.pend_load) begin
         pend_valid_in = 1'b1;
      end else if (cmd.pend_clr) begin
         pend_valid_in = 1'b0;
      end
   end

   assign ram_we    = cmd.alloc | cmd.dec;
   assign ram_wdata = cmd.alloc ? {next_id_ff, dur_ff}
                                : {rd_id, DURATION_W'(rd_rem - 1'b1)};

   mstt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   always_comb begin
      case (cmd.out_id_sel)
         ID_NEXT: rsp_id_in = HANDLE_W'(next_id_ff);
         ID_PEND: rsp_id_in = HANDLE_W'(pend_id_ff);
         default: rsp_id_in = '0;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         live_ff       <= '0;
         cancel_ff     <= '0;
         next_id_ff    <= ID_BITS'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         live_ff       <= live_in;
         cancel_ff     <= cancel_in;
         next_id_ff    <= next_id_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         dur_ff <= req_duration_ms;
         cid_ff <= req_cancel_id;
      end
      if (cmd.pend_load) begin
         pend_id_ff <= rd_id;
      end
      if (cmd.out_load) begin
         rsp_kind_ff <= cmd.out_kind;
         rsp_ok_ff   <= cmd.out_ok;
         rsp_last_ff <= cmd.out_last;
         rsp_id_ff   <= rsp_id_in;
      end
   end

   assign status.idx_end    = idx_end;
   assign status.live       = live_ff[idx_ff];
   assign status.cancelled  = cancel_ff[idx_ff];
   assign status.id_match   = (cid_ff == HANDLE_W'(rd_id));
   assign status.rem_zero   = (rd_rem == '0);
   assign status.out_free   = ~rsp_valid_ff | rsp_ready;
   assign status.pend_valid = pend_valid_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_handle = rsp_id_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ rtl/multi_slot_timer_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_timer_table
// table of one-shot millisecond timer slots with set, cancel and tick requests
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready is high only while the block is
// idle. Every request walks the slot table one slot per cycle through the
// single read port of the slot ram: a set stops at the first free slot, or at
// the last slot when the table is full; a cancel stops at the matching slot, or
// at the last slot when nothing is found; a tick visits every slot and then
// hands out any held expiry before the block returns to idle. Cycles in which a
// result cannot be handed to the result register (rsp_valid high and rsp_ready
// low) stretch the scan. A set or cancel gives one reply; a tick gives one
// expiry report per timer that runs out, in slot order, with last set on the
// final one, and no result at all when nothing expires. A timer set with
// duration d expires on the (d+1)-th tick after it was set. Ids run 1 ..
// 2^ID_BITS-1 and wrap to 1. Opcode 3 is taken and ignored.
// ----------------------------------------------------------------------------
module multi_slot_timer_table
   import mstt_pkg::*;
#(
   parameter int NUM_SLOTS = 16,
   parameter int ID_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [DURATION_W-1:0] req_duration_ms,
   input  logic [HANDLE_W-1:0]   req_cancel_id,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic                  rsp_ok,
   output logic [HANDLE_W-1:0]   rsp_handle,
   output logic                  rsp_last
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // sequencer: decides per slot what to do and when a result goes out
   mstt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: slot ram, live and cancel marks, id counter, result register
   mstt_dpath #(
      .NUM_SLOTS (NUM_SLOTS),
      .ID_BITS   (ID_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_duration_ms (req_duration_ms),
      .req_cancel_id   (req_cancel_id),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_ok          (rsp_ok),
      .rsp_handle      (rsp_handle),
      .rsp_last        (rsp_last)
   );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-slot timer table
// ----------------------------------------------------------------------------
// A short directed run walks the corner cases of set, cancel and tick. It
// covers an empty tick, the ignored opcode, cancels of id 0, of an absent id
// and of an id already cancelled, a cancelled slot that is held until the next
// tick, and the extreme durations. A random run follows, built mostly from
// short timers so that expiries are frequent, with bursts of sets that fill
// the table and then probe it. Every accepted request goes through a
// behavioral copy of the slot table. The replies that it predicts are matched
// in order, field by field, against the result channel. The sender works in
// random bursts and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_top
   import mstt_pkg::*;
();

   localparam int SLOTS         = 16;
   localparam int RANDOM_REQS   = 140;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4 * SLOTS;

   // opcode 3 has no meaning; the block takes it and drops it
   localparam op_code_type OP_UNUSED = 2'd3;
   localparam logic [HANDLE_W-1:0]   ID_MAX  = '1;
   localparam logic [DURATION_W-1:0] DUR_MAX = '1;

   typedef struct {
      op_code_type           op;
      logic [DURATION_W-1:0] duration;
      logic [HANDLE_W-1:0]   cancel_id;
   } timer_request_type;

   typedef struct {
      kind_type              kind;
      logic                  ok;
      logic [HANDLE_W-1:0]   handle;
      logic                  last;
   } timer_reply_type;

   // clock, reset and block inputs, all known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic [OP_W-1:0]       req_op = OP_TICK;
   logic [DURATION_W-1:0] req_duration_ms = '0;
   logic [HANDLE_W-1:0]   req_cancel_id = '0;
   logic                  rsp_ready = 1'b0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic [KIND_W-1:0]     rsp_kind;
   logic                  rsp_ok;
   logic [HANDLE_W-1:0]   rsp_handle;
   logic                  rsp_last;

   // requests waiting for the driver, replies waiting for the monitor
   timer_request_type request_queue[$];
   timer_reply_type   due_replies[$];

   // behavioral copy of the slot table
   logic [HANDLE_W-1:0]   tbl_id[SLOTS];
   logic [DURATION_W-1:0] tbl_left[SLOTS];
   logic                  tbl_cancelled[SLOTS];
   logic [HANDLE_W-1:0]   tbl_next_id;

   // tallies for the closing summary
   int n_set_ok, n_set_full, n_cancel_ok, n_cancel_fail;
   int n_ticks, n_expired, n_ignored, n_checked, n_errors;
   int sets_queued;

   // sender burst shaping and receiver stall pattern
   int burst_left, gap_left;
   int stall_mode, stall_left, stall_phase;
   int idle_cycles;

   multi_slot_timer_table #(
      .NUM_SLOTS (SLOTS),
      .ID_BITS   (HANDLE_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_duration_ms (req_duration_ms),
      .req_cancel_id   (req_cancel_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_ok          (rsp_ok),
      .rsp_handle      (rsp_handle),
      .rsp_last        (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // table model: updates the copy of the slot table for one accepted request
   // and queues the replies that the request must produce
   // --------------------------------------------------------------------------
   task automatic apply_timer_request(input op_code_type op,
                                      input logic [DURATION_W-1:0] dur,
                                      input logic [HANDLE_W-1:0] cid);
      int  s;
      int  hit;
      int  n_exp;
      logic ok;
      begin
         case (op)
            OP_SET: begin
               // first slot that is free and not waiting on a cancel
               hit = -1;
               for (s = 0; s < SLOTS; s++)
                  if (hit < 0 && tbl_id[s] == '0 && !tbl_cancelled[s])
                     hit = s;
               if (hit < 0) begin
                  due_replies.push_back('{KIND_SET, 1'b0, '0, 1'b1});
                  n_set_full++;
               end else begin
                  tbl_id[hit]        = tbl_next_id;
                  tbl_left[hit]      = dur;
                  tbl_cancelled[hit] = 1'b0;
                  due_replies.push_back('{KIND_SET, 1'b1, tbl_next_id, 1'b1});
                  // ids skip 0 on wrap
                  tbl_next_id = (tbl_next_id == ID_MAX) ? 1 : tbl_next_id + 1;
                  n_set_ok++;
               end
            end
            OP_CANCEL: begin
               // id 0 never matches; a second cancel of the same id fails
               ok  = 1'b0;
               hit = 0;
               if (cid != '0) begin
                  for (s = 0; s < SLOTS; s++) begin
                     if (!hit && tbl_id[s] == cid) begin
                        hit = 1;
                        if (!tbl_cancelled[s]) begin
                           tbl_cancelled[s] = 1'b1;
                           ok = 1'b1;
                        end
                     end
                  end
               end
               due_replies.push_back('{KIND_CANCEL, ok, '0, 1'b1});
               if (ok) n_cancel_ok++;
               else n_cancel_fail++;
            end
            OP_TICK: begin
               n_exp = 0;
               for (s = 0; s < SLOTS; s++) begin
                  if (tbl_id[s] != '0) begin
                     if (tbl_cancelled[s]) begin
                        tbl_id[s]        = '0;
                        tbl_left[s]      = '0;
                        tbl_cancelled[s] = 1'b0;
                     end else if (tbl_left[s] == '0) begin
                        due_replies.push_back('{KIND_EXPIRY, 1'b1, tbl_id[s], 1'b0});
                        n_exp++;
                        tbl_id[s]   = '0;
                        tbl_left[s] = '0;
                     end else begin
                        tbl_left[s] = tbl_left[s] - 1;
                     end
                  end
               end
               // last marks the final expiry of this tick
               if (n_exp > 0)
                  due_replies[due_replies.size() - 1].last = 1'b1;
               n_ticks++;
               n_expired += n_exp;
            end
            default: n_ignored++;
         endcase
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      begin
         if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, what,
                     want, got);
            n_errors++;
         end
      end
   endtask

   task automatic queue_request(input op_code_type op, input logic [DURATION_W-1:0] dur,
                                input logic [HANDLE_W-1:0] cid);
      begin
         request_queue.push_back('{op, dur, cid});
         if (op == OP_SET) sets_queued++;
      end
   endtask

   // mostly short timers so expiries are frequent, a few long and extreme ones
   function automatic logic [DURATION_W-1:0] rand_duration();
      int r;
      begin
         r = $urandom_range(0, 99);
         if (r < 75) return $urandom_range(0, 6);
         if (r < 88) return $urandom_range(7, 40);
         if (r < 95) return $urandom();
         return (r & 1) ? DUR_MAX : '0;
      end
   endfunction

   // ids handed out so far are at most sets_queued, so aim near the top of that
   function automatic logic [HANDLE_W-1:0] rand_cancel_id();
      int r;
      int lo;
      begin
         r  = $urandom_range(0, 99);
         lo = (sets_queued > 20) ? sets_queued - 20 : 1;
         if (r < 8) return '0;
         if (r < 18) return $urandom();
         return $urandom_range(lo, sets_queued + 2);
      end
   endfunction

   // wait until the driver is empty and every predicted reply has come
   task automatic wait_drained();
      begin
         while (request_queue.size() != 0 || req_valid || due_replies.size() != 0)
            @(negedge clock);
      end
   endtask

   // --------------------------------------------------------------------------
   // driver: presents requests in bursts of random length with random gaps,
   // holding each one until the block takes it
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready)
            apply_timer_request(req_op, req_duration_ms, req_cancel_id);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               req_op          <= request_queue[0].op;
               req_duration_ms <= request_queue[0].duration;
               req_cancel_id   <= request_queue[0].cancel_id;
               req_valid       <= 1'b1;
               void'(request_queue.pop_front());
               if (burst_left <= 1) begin
                  // a third of the gaps are empty, giving long unbroken stretches
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // monitor: checks each accepted result against the oldest predicted reply
   // and drives the receiver stall pattern
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_mode  <= 0;
         stall_left  <= 0;
         stall_phase <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_checked++;
            if (due_replies.size() == 0) begin
               $display("%0t: unexpected result: kind %0h ok %0b id %0h last %0b",
                        $realtime, rsp_kind, rsp_ok, rsp_handle, rsp_last);
               n_errors++;
            end else begin
               check_field("kind", due_replies[0].kind, rsp_kind);
               check_field("ok", due_replies[0].ok, rsp_ok);
               check_field("handle", due_replies[0].handle, rsp_handle);
               check_field("last", due_replies[0].last, rsp_last);
               void'(due_replies.pop_front());
            end
         end
         // modes: always ready, random 70 percent, one cycle in three
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 80);
         end else begin
            stall_left <= stall_left - 1;
         end
         stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            default: rsp_ready <= (stall_phase == 0);
         endcase
      end
   end

   // watchdog on cycles in which neither channel moves anything
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no request or result moved for %0d cycles", $realtime, IDLE_LIMIT);
         $display("** multi_slot_timer_table: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus and end of run
   // --------------------------------------------------------------------------
   initial begin
      int  pick;
      int  n_fill;
      int  k;
      int  n_random;
      bit  paused;
      for (k = 0; k < SLOTS; k++) begin
         tbl_id[k]        = '0;
         tbl_left[k]      = '0;
         tbl_cancelled[k] = 1'b0;
      end
      tbl_next_id = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corner cases
      queue_request(OP_TICK, '0, '0);           // tick on an empty table
      queue_request(OP_UNUSED, DUR_MAX, ID_MAX); // dropped opcode
      queue_request(OP_CANCEL, DUR_MAX, '0);     // cancel of id 0
      queue_request(OP_CANCEL, '0, ID_MAX);      // cancel of an absent id
      queue_request(OP_SET, '0, '0);             // id 1, would expire on next tick
      queue_request(OP_SET, DUR_MAX, '0);        // id 2, never runs out
      queue_request(OP_SET, '0, '0);             // id 3
      queue_request(OP_CANCEL, '0, 1);           // cancel of a zero-length timer
      queue_request(OP_CANCEL, '0, 1);           // cancel of an id already cancelled
      queue_request(OP_SET, 5, '0);              // cancelled slot still held
      queue_request(OP_TICK, '0, '0);            // frees slot 0, id 3 expires
      queue_request(OP_SET, '0, '0);
      queue_request(OP_SET, 1, '0);
      queue_request(OP_TICK, '0, '0);
      queue_request(OP_TICK, '0, '0);
      queue_request(OP_CANCEL, '0, 2);
      queue_request(OP_TICK, '0, '0);
      queue_request(OP_CANCEL, '0, 2);           // gone after the tick
      queue_request(OP_SET, 32'h5A5A_A5A5, '0);
      queue_request(OP_CANCEL, '0, 32'hA5A5_5A5A);
      queue_request(OP_TICK, '0, '0);

      // sender holds off until every reply is back
      wait_drained();

      n_random = 0;
      paused   = 1'b0;
      while (n_random < RANDOM_REQS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // fill the table, probe a cancelled slot, then let a tick clear it
            n_fill = $urandom_range(SLOTS - 2, SLOTS + 2);
            for (k = 0; k < n_fill; k++)
               queue_request(OP_SET, $urandom_range(0, 8), '0);
            queue_request(OP_CANCEL, '0, $urandom_range(sets_queued - n_fill + 1, sets_queued));
            queue_request(OP_SET, rand_duration(), '0);
            queue_request(OP_TICK, '0, '0);
            n_random += n_fill + 3;
         end else if (pick < 40) begin
            queue_request(OP_SET, rand_duration(), $urandom());
            n_random++;
         end else if (pick < 70) begin
            queue_request(OP_TICK, $urandom(), $urandom());
            n_random++;
         end else if (pick < 95) begin
            queue_request(OP_CANCEL, $urandom(), rand_cancel_id());
            n_random++;
         end else begin
            queue_request(OP_UNUSED, $urandom(), $urandom());
            n_random++;
         end
         if (!paused && n_random >= RANDOM_REQS / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end

      // drain, then give the block time to show any stray result
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d sets (%0d refused on a full table), %0d cancels (%0d rejected),",
               n_set_ok + n_set_full, n_set_full, n_cancel_ok + n_cancel_fail, n_cancel_fail);
      $display("%0d ticks with %0d expiries, %0d dropped opcodes; %0d results checked",
               n_ticks, n_expired, n_ignored, n_checked);
      if (n_errors == 0) begin
         $display("** multi_slot_timer_table: PASSED **");
      end else begin
         $display("** multi_slot_timer_table: FAILED **");
      end
      $finish;
   end

endmodule

@@ multi_slot_timer_table.f @@
rtl/mstt_pkg.sv
rtl/mstt_ram.sv
rtl/mstt_ctrl.sv
rtl/mstt_dpath.sv
rtl/multi_slot_timer_table.sv
test/tb_top.sv
